@@ sv/sbot_pkg.sv @@
// ----------------------------------------------------------------------------
// sbot_pkg
// Shared constants and types for the segment versus box overlap test core.
// ----------------------------------------------------------------------------
package sbot_pkg;

    // Default coordinate width: signed Q16.8.
    localparam int COORD_BITS_DEF = 24;

    // Configuration bus geometry: four 32-bit registers at byte offsets 0..12.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_BOX_MIN_X = 2'd0,
        REG_BOX_MIN_Y = 2'd1,
        REG_BOX_MAX_X = 2'd2,
        REG_BOX_MAX_Y = 2'd3
    } t_reg_idx;

endpackage

@@ sv/sbot_regs.sv @@
// ----------------------------------------------------------------------------
// sbot_regs
// APB register file holding the four box edges.
// ----------------------------------------------------------------------------
module sbot_regs #(
    parameter int COORD_BITS = sbot_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sbot_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [sbot_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sbot_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic signed [COORD_BITS-1:0]         o_box_min_x,
    output logic signed [COORD_BITS-1:0]         o_box_min_y,
    output logic signed [COORD_BITS-1:0]         o_box_max_x,
    output logic signed [COORD_BITS-1:0]         o_box_max_y
);
    import sbot_pkg::*;

    logic signed [COORD_BITS-1:0] r_box_min_x;
    logic signed [COORD_BITS-1:0] r_box_min_y;
    logic signed [COORD_BITS-1:0] r_box_max_x;
    logic signed [COORD_BITS-1:0] r_box_max_y;
    logic                         wr_en;
    t_reg_idx                     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min_x <= '0;
            r_box_min_y <= '0;
            r_box_max_x <= '0;
            r_box_max_y <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BOX_MIN_X: r_box_min_x <= pwdata[COORD_BITS-1:0];
                REG_BOX_MIN_Y: r_box_min_y <= pwdata[COORD_BITS-1:0];
                REG_BOX_MAX_X: r_box_max_x <= pwdata[COORD_BITS-1:0];
                REG_BOX_MAX_Y: r_box_max_y <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Reads return the register sign-extended to the bus width.
    always_comb begin
        case (reg_idx)
            REG_BOX_MIN_X: prdata = APB_DATA_W'(r_box_min_x);
            REG_BOX_MIN_Y: prdata = APB_DATA_W'(r_box_min_y);
            REG_BOX_MAX_X: prdata = APB_DATA_W'(r_box_max_x);
            REG_BOX_MAX_Y: prdata = APB_DATA_W'(r_box_max_y);
            default:       prdata = '0;
        endcase
    end

    assign o_box_min_x = r_box_min_x;
    assign o_box_min_y = r_box_min_y;
    assign o_box_max_x = r_box_max_x;
    assign o_box_max_y = r_box_max_y;

endmodule

@@ sv/segment_box_overlap_test_core.sv @@
// ----------------------------------------------------------------------------
// segment_box_overlap_test_core
// Tests a 2D line segment against an axis-aligned box, exactly, in fixed point.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   -------   ---------  ------------------------  ---------------------------------
//   request   in         start, busy (always low)  i_start_x, i_start_y, i_end_x,
//                                                  i_end_y (signed Q16.8)
//   result    out        o_done (one-cycle strobe) o_hit
//   config    in/out     APB psel/penable/pwrite   box_min_x/min_y/max_x/max_y
//
// A request is taken in every cycle in which start is high; busy never rises.
// Each request yields exactly one result, in request order. o_done rises once
// the request has passed the four register stages: endpoint ordering,
// clipping and differences, the four cross products, and the final sign tests.
// Reset is synchronous and active low; it clears the stage valid bits and the
// box registers. The receiver cannot stall, so the pipeline never holds.
//
// The segment's y at a clipped x bound X is y0 + dy*(X-x0)/dx. Comparing it
// with a box edge Y is done without division as the sign of
// (y0-Y)*dx + dy*(X-x0), since dx is positive once the endpoints are ordered.
// ----------------------------------------------------------------------------
module segment_box_overlap_test_core #(
    parameter int COORD_BITS = sbot_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Request channel.
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_BITS-1:0]         i_start_x,
    input  logic signed [COORD_BITS-1:0]         i_start_y,
    input  logic signed [COORD_BITS-1:0]         i_end_x,
    input  logic signed [COORD_BITS-1:0]         i_end_y,
    // Result channel.
    output logic                                 o_done,
    output logic                                 o_hit,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sbot_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [sbot_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sbot_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import sbot_pkg::*;

    // Differences of two coordinates need one extra bit; products of two
    // differences need twice that; the sum of two products one more.
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;

    sbot_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_box_min_x (box_min_x),
        .o_box_min_y (box_min_y),
        .o_box_max_x (box_max_x),
        .o_box_max_y (box_max_y)
    );

    // The pipeline never stalls, so a request is always welcome.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: order the endpoints so that x0 <= x1. Swapping both
    // coordinates together leaves the line unchanged.
    // ------------------------------------------------------------------
    logic                         r_s1_v;
    logic signed [COORD_BITS-1:0] r_s1_x0, r_s1_y0, r_s1_x1, r_s1_y1;
    logic                         swap;

    assign swap = i_start_x > i_end_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x0 <= swap ? i_end_x   : i_start_x;
        r_s1_y0 <= swap ? i_end_y   : i_start_y;
        r_s1_x1 <= swap ? i_start_x : i_end_x;
        r_s1_y1 <= swap ? i_start_y : i_end_y;
    end

    // ------------------------------------------------------------------
    // Stage 2: clip the x-extent to the box, flag the early-out cases and
    // form the differences that feed the cross products.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] x0_e, y0_e, x1_e, y1_e;
    logic signed [DW-1:0] bx0_e, by0_e, bx1_e, by1_e;
    logic                 n_s2_miss, n_s2_vert, n_s2_vhit;
    logic signed [DW-1:0] n_s2_dx, n_s2_dy, n_s2_da, n_s2_db, n_s2_lox, n_s2_hix;

    logic                 r_s2_v, r_s2_miss, r_s2_vert, r_s2_vhit;
    logic signed [DW-1:0] r_s2_dx, r_s2_dy, r_s2_da, r_s2_db, r_s2_lox, r_s2_hix;

    always_comb begin
        x0_e  = DW'(r_s1_x0);
        y0_e  = DW'(r_s1_y0);
        x1_e  = DW'(r_s1_x1);
        y1_e  = DW'(r_s1_y1);
        bx0_e = DW'(box_min_x);
        by0_e = DW'(box_min_y);
        bx1_e = DW'(box_max_x);
        by1_e = DW'(box_max_y);

        // The clipped range max(x0,bx0)..min(x1,bx1) is empty when any lower
        // bound exceeds any upper bound; an inverted y-range also misses.
        n_s2_miss = (r_s1_x0 > box_max_x) || (box_min_x > r_s1_x1) ||
                    (box_min_x > box_max_x) || (box_min_y > box_max_y);

        // A vertical segment is tested on its own endpoint y-range.
        n_s2_vert = r_s1_x0 == r_s1_x1;
        n_s2_vhit = ((r_s1_y0 <= box_max_y) || (r_s1_y1 <= box_max_y)) &&
                    ((r_s1_y0 >= box_min_y) || (r_s1_y1 >= box_min_y));

        n_s2_dx  = x1_e - x0_e;
        n_s2_dy  = y1_e - y0_e;
        n_s2_da  = y0_e - by1_e;
        n_s2_db  = y0_e - by0_e;
        // Clipped bounds relative to x0.
        n_s2_lox = (box_min_x > r_s1_x0) ? (bx0_e - x0_e) : '0;
        n_s2_hix = (r_s1_x1 < box_max_x) ? n_s2_dx : (bx1_e - x0_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_miss <= n_s2_miss;
        r_s2_vert <= n_s2_vert;
        r_s2_vhit <= n_s2_vhit;
        r_s2_dx   <= n_s2_dx;
        r_s2_dy   <= n_s2_dy;
        r_s2_da   <= n_s2_da;
        r_s2_db   <= n_s2_db;
        r_s2_lox  <= n_s2_lox;
        r_s2_hix  <= n_s2_hix;
    end

    // ------------------------------------------------------------------
    // Stage 3: the four cross products, one multiplier each.
    // ------------------------------------------------------------------
    logic                 r_s3_v, r_s3_miss, r_s3_vert, r_s3_vhit;
    logic signed [PW-1:0] r_s3_pa, r_s3_pb, r_s3_plo, r_s3_phi;
    logic signed [PW-1:0] dx_w, dy_w, da_w, db_w, lox_w, hix_w;

    always_comb begin
        dx_w  = PW'(r_s2_dx);
        dy_w  = PW'(r_s2_dy);
        da_w  = PW'(r_s2_da);
        db_w  = PW'(r_s2_db);
        lox_w = PW'(r_s2_lox);
        hix_w = PW'(r_s2_hix);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_miss <= r_s2_miss;
        r_s3_vert <= r_s2_vert;
        r_s3_vhit <= r_s2_vhit;
        r_s3_pa   <= da_w * dx_w;
        r_s3_pb   <= db_w * dx_w;
        r_s3_plo  <= dy_w * lox_w;
        r_s3_phi  <= dy_w * hix_w;
    end

    // ------------------------------------------------------------------
    // Stage 4: signs of the four sums and the final decision. The segment
    // is at or below the top edge at some clipped bound and at or above the
    // bottom edge at some clipped bound exactly when it touches the box.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] s_lo_max, s_hi_max, s_lo_min, s_hi_min;
    logic                 le_lo_max, le_hi_max, ge_lo_min, ge_hi_min;
    logic                 n_hit;

    always_comb begin
        s_lo_max  = SW'(r_s3_pa) + SW'(r_s3_plo);
        s_hi_max  = SW'(r_s3_pa) + SW'(r_s3_phi);
        s_lo_min  = SW'(r_s3_pb) + SW'(r_s3_plo);
        s_hi_min  = SW'(r_s3_pb) + SW'(r_s3_phi);
        le_lo_max = s_lo_max[SW-1] || (s_lo_max == '0);
        le_hi_max = s_hi_max[SW-1] || (s_hi_max == '0);
        ge_lo_min = !s_lo_min[SW-1];
        ge_hi_min = !s_hi_min[SW-1];

        if (r_s3_miss) begin
            n_hit = 1'b0;
        end else if (r_s3_vert) begin
            n_hit = r_s3_vhit;
        end else begin
            n_hit = (le_lo_max || le_hi_max) && (ge_lo_min || ge_hi_min);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit <= n_hit;
    end

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v |=> o_done)
        else $error("valid request in the last stage produced no result");

    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s3_v |=> !o_done)
        else $error("result strobe without a request behind it");

    a_miss_is_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_v && r_s3_miss) |=> (o_done && !o_hit))
        else $error("empty clipped range reported as a hit");

    a_vertical : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_v && !r_s3_miss && r_s3_vert) |=> (o_hit == $past(r_s3_vhit)))
        else $error("vertical segment result differs from its y-range test");

endmodule
